>>> rtl/nbfb_pkg.sv
// shared types, codes and fixed-point helpers of the noise band-pass filter bank
// no dependencies
package nbfb_pkg;

    localparam int MAX_HARMONICS_DEF = 64;
    localparam int MAX_STAGES_DEF    = 5;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_UPDATE  = 2'd1;
    localparam logic [1:0] REQ_ROLLOFF = 2'd2;
    localparam logic [1:0] REQ_SAMPLE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_HARMONICS = 1'b0;
    localparam logic CFG_STAGES    = 1'b1;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        word_t b0;
        word_t b2;
        word_t fb1;
        word_t fb2;
    } coef_t;

    typedef struct packed {
        word_t x1;
        word_t x2;
        word_t y1;
        word_t y2;
    } hist_t;

    typedef struct packed {
        logic coef_we;
        logic hist_we;
        logic scale_we;
        logic rd_en;
    } mem_ctl_t;

    // round a q48 product to q24: add half, arithmetic shift by 24
    function automatic logic signed [39:0] round_q24(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = p + 64'sd8388608;
        return $signed(v[63:24]);
    endfunction

    // saturate to 32 bits, clip flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [41:0] v);
        logic [32:0] r;
        if (v > 42'sd2147483647)
            r = {1'b1, 32'h7fff_ffff};
        else if (v < -42'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

>>> rtl/nbfb_slot_mem.sv
// coefficient, history and rolloff memories of the filter bank
// depends on nbfb_pkg; history is swept to zero after reset
module nbfb_slot_mem #(
    parameter int MAX_HARMONICS = nbfb_pkg::MAX_HARMONICS_DEF,
    parameter int MAX_STAGES    = nbfb_pkg::MAX_STAGES_DEF,
    localparam int SLOTS   = MAX_HARMONICS * MAX_STAGES,
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int HIDX_W  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbfb_pkg::mem_ctl_t   ctl,
    input  logic [SLOT_AW-1:0]   wr_addr,
    input  logic [SLOT_AW-1:0]   rd_addr,
    input  nbfb_pkg::coef_t      coef_wdata,
    input  nbfb_pkg::hist_t      hist_wdata,
    input  logic [HIDX_W-1:0]    scale_waddr,
    input  logic [24:0]          scale_wdata,
    input  logic [HIDX_W-1:0]    scale_raddr,
    output nbfb_pkg::coef_t      coef_rdata,
    output nbfb_pkg::hist_t      hist_rdata,
    output logic [24:0]          scale_rdata,
    output logic                 clear_busy
);
    import nbfb_pkg::*;

    coef_t       coef_mem  [SLOTS];
    hist_t       hist_mem  [SLOTS];
    logic [24:0] scale_mem [MAX_HARMONICS];

    logic               clr_busy_reg;
    logic [SLOT_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == SLOT_AW'(SLOTS - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign clear_busy = clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.coef_we)
            coef_mem[wr_addr] <= coef_wdata;
        if (ctl.rd_en)
            coef_rdata <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            hist_mem[clr_addr_reg] <= '0;
        else if (ctl.hist_we)
            hist_mem[wr_addr] <= hist_wdata;
        if (ctl.rd_en)
            hist_rdata <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scale_we)
            scale_mem[scale_waddr] <= scale_wdata;
        if (ctl.rd_en)
            scale_rdata <= scale_mem[scale_raddr];
    end

endmodule

>>> rtl/nbfb_mac.sv
// one biquad evaluation: four registered products, rounded sum, saturation
// depends on nbfb_pkg
module nbfb_mac (
    input  logic             clk,
    input  logic             mul_en,
    input  nbfb_pkg::word_t  x,
    input  nbfb_pkg::coef_t  coef,
    input  nbfb_pkg::hist_t  hist,
    output nbfb_pkg::word_t  y,
    output logic             clipped
);
    import nbfb_pkg::*;

    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [41:0] sum;
    logic [32:0]        res;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            p0_reg <= $signed(coef.b0)  * $signed(x);
            p1_reg <= $signed(coef.b2)  * $signed(hist.x2);
            p2_reg <= $signed(coef.fb1) * $signed(hist.y1);
            p3_reg <= $signed(coef.fb2) * $signed(hist.y2);
        end
    end

    always_comb
    begin
        sum = 42'(round_q24(p0_reg)) + 42'(round_q24(p1_reg))
            + 42'(round_q24(p2_reg)) + 42'(round_q24(p3_reg));
        res = sat32(sum);
    end

    assign y       = $signed(res[31:0]);
    assign clipped = res[32];

endmodule

>>> rtl/noise_bandpass_filter_bank.sv
// top level of the noise band-pass filter bank: item decode, slot sequencer,
// rolloff scaling and output register; uses nbfb_pkg, nbfb_slot_mem, nbfb_mac
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   req_type harmonic stage coef_* start_y* rolloff_gain sample_in
//  out      out  out_valid/out_stall sample_out saturated
//  cfg      in   cfg_valid/cfg_ready cfg_index cfg_data
//
// load, update and rolloff beats are written to memory in the accept cycle
// a sample beat is worked off in steps: read, multiply and accumulate per
//   stage through the one slot memory read port, then scale and sum per harmonic
// reset starts a history clearing pass over all MAX_HARMONICS*MAX_STAGES slots,
//   in_stall stays high meanwhile; cfg beats are always taken
// a finished result waits in the output register under out_stall while the
//   next beat is accepted
module noise_bandpass_filter_bank #(
    parameter int MAX_HARMONICS = nbfb_pkg::MAX_HARMONICS_DEF,
    parameter int MAX_STAGES    = nbfb_pkg::MAX_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [5:0]          harmonic,
    input  logic [2:0]          stage,
    input  nbfb_pkg::word_t     coef_b0,
    input  nbfb_pkg::word_t     coef_b2,
    input  nbfb_pkg::word_t     coef_fb1,
    input  nbfb_pkg::word_t     coef_fb2,
    input  nbfb_pkg::word_t     start_y1,
    input  nbfb_pkg::word_t     start_y2,
    input  logic [24:0]         rolloff_gain,
    input  logic signed [23:0]  sample_in,
    output logic                out_valid,
    input  logic                out_stall,
    output nbfb_pkg::word_t     sample_out,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);
    import nbfb_pkg::*;

    localparam int SLOTS   = MAX_HARMONICS * MAX_STAGES;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HIDX_W  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int SIDX_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // configuration registers
    logic [6:0] harm_cfg_reg;
    logic [2:0] stage_cfg_reg;

    // sequencer
    logic [2:0]          state_reg, state_next;
    logic [HIDX_W-1:0]   k_reg, k_next, last_h_reg, last_h_next;
    logic [SIDX_W-1:0]   j_reg, j_next, last_s_reg, last_s_next;
    logic [SLOT_AW-1:0]  slot_reg, slot_next, base_reg, base_next;
    word_t               x_reg, x_next, v_reg, v_next;
    logic signed [39:0]  acc_reg, acc_next;
    logic                flag_reg, flag_next;
    logic signed [57:0]  sprod_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    word_t               out_data_reg, out_data_next;
    logic                out_sat_reg, out_sat_next;

    // memory interface
    mem_ctl_t            ctl;
    logic [SLOT_AW-1:0]  wr_addr, item_addr;
    coef_t               coef_wdata, coef_rdata;
    hist_t               hist_wdata, hist_rdata;
    logic [24:0]         scale_wdata, scale_rdata;
    logic                clear_busy;

    word_t               mac_y;
    logic                mac_clip;

    logic                accept, slot_ok, harm_ok;
    logic [32:0]         fin;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || clear_busy;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harm_cfg_reg  <= 7'd1;
            stage_cfg_reg <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HARMONICS: harm_cfg_reg  <= cfg_data;
                CFG_STAGES:    stage_cfg_reg <= cfg_data[2:0];
                default:       harm_cfg_reg  <= harm_cfg_reg;
            endcase
        end
    end

    // slot address of a load or update beat
    assign harm_ok   = int'(harmonic) < MAX_HARMONICS;
    assign slot_ok   = harm_ok && (int'(stage) < MAX_STAGES);
    assign item_addr = SLOT_AW'(int'(harmonic) * MAX_STAGES + int'(stage));

    always_comb
    begin
        ctl.coef_we  = accept && slot_ok
                       && (req_type == REQ_LOAD || req_type == REQ_UPDATE);
        ctl.hist_we  = (accept && slot_ok && req_type == REQ_LOAD)
                       || (state_reg == ST_ACC);
        ctl.scale_we = accept && harm_ok && req_type == REQ_ROLLOFF;
        ctl.rd_en    = (state_reg == ST_READ);

        wr_addr = (state_reg == ST_ACC) ? slot_reg : item_addr;

        coef_wdata.b0  = coef_b0;
        coef_wdata.b2  = coef_b2;
        coef_wdata.fb1 = coef_fb1;
        coef_wdata.fb2 = coef_fb2;

        if (state_reg == ST_ACC)
        begin
            // shift the history of the running slot
            hist_wdata.x1 = v_reg;
            hist_wdata.x2 = hist_rdata.x1;
            hist_wdata.y1 = mac_y;
            hist_wdata.y2 = hist_rdata.y1;
        end
        else
        begin
            hist_wdata.x1 = '0;
            hist_wdata.x2 = '0;
            hist_wdata.y1 = start_y1;
            hist_wdata.y2 = start_y2;
        end

        scale_wdata = (rolloff_gain > ONE_Q24) ? ONE_Q24 : rolloff_gain;
    end

    nbfb_slot_mem #(
        .MAX_HARMONICS (MAX_HARMONICS),
        .MAX_STAGES    (MAX_STAGES)
    ) u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .wr_addr     (wr_addr),
        .rd_addr     (slot_reg),
        .coef_wdata  (coef_wdata),
        .hist_wdata  (hist_wdata),
        .scale_waddr (harmonic[HIDX_W-1:0]),
        .scale_wdata (scale_wdata),
        .scale_raddr (k_reg),
        .coef_rdata  (coef_rdata),
        .hist_rdata  (hist_rdata),
        .scale_rdata (scale_rdata),
        .clear_busy  (clear_busy)
    );

    nbfb_mac u_mac (
        .clk     (clk),
        .mul_en  (state_reg == ST_MUL),
        .x       (v_reg),
        .coef    (coef_rdata),
        .hist    (hist_rdata),
        .y       (mac_y),
        .clipped (mac_clip)
    );

    // rolloff product of the finished cascade output
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCALE)
            sprod_reg <= $signed(v_reg) * $signed({1'b0, scale_rdata});
    end

    assign fin = sat32(42'(acc_reg));

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        last_h_next    = last_h_reg;
        last_s_next    = last_s_reg;
        slot_next      = slot_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_SAMPLE)
                begin
                    // q1.23 sample enters as q8.24
                    x_next    = {{7{sample_in[23]}}, sample_in, 1'b0};
                    v_next    = {{7{sample_in[23]}}, sample_in, 1'b0};
                    k_next    = '0;
                    j_next    = '0;
                    slot_next = '0;
                    base_next = '0;
                    acc_next  = '0;
                    flag_next = 1'b0;
                    // zero acts as one, large values clamp to the maximum
                    if (harm_cfg_reg == 7'd0)
                        last_h_next = '0;
                    else if (int'(harm_cfg_reg) > MAX_HARMONICS)
                        last_h_next = HIDX_W'(MAX_HARMONICS - 1);
                    else
                        last_h_next = HIDX_W'(harm_cfg_reg - 7'd1);
                    if (stage_cfg_reg == 3'd0)
                        last_s_next = '0;
                    else if (int'(stage_cfg_reg) > MAX_STAGES)
                        last_s_next = SIDX_W'(MAX_STAGES - 1);
                    else
                        last_s_next = SIDX_W'(stage_cfg_reg - 3'd1);
                    state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                v_next    = mac_y;
                flag_next = flag_reg | mac_clip;
                if (j_reg == last_s_reg)
                    state_next = ST_SCALE;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_SCALE:
                state_next = ST_SUM;
            ST_SUM:
            begin
                acc_next = acc_reg + round_q24(64'(sprod_reg));
                if (k_reg == last_h_reg)
                    state_next = ST_DONE;
                else
                begin
                    // next harmonic starts from the excitation again
                    k_next     = k_reg + 1'b1;
                    j_next     = '0;
                    base_next  = base_reg + SLOT_AW'(MAX_STAGES);
                    slot_next  = base_reg + SLOT_AW'(MAX_STAGES);
                    v_next     = x_reg;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = $signed(fin[31:0]);
                    out_sat_next   = flag_reg | fin[32];
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            j_reg         <= '0;
            last_h_reg    <= '0;
            last_s_reg    <= '0;
            slot_reg      <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            last_h_reg    <= last_h_next;
            last_s_reg    <= last_s_next;
            slot_reg      <= slot_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        v_reg        <= v_next;
        acc_reg      <= acc_next;
        flag_reg     <= flag_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign saturated  = out_sat_reg;

    // the clearing pass never overlaps sample work
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> state_reg == ST_IDLE)
        else $error("clearing pass overlaps sample work");

    // coefficients never change under a running sample
    a_no_coef_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !ctl.coef_we && !ctl.scale_we)
        else $error("coefficient write during sample work");

    // counters stay inside the configured cascade
    a_counters: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> j_reg <= last_s_reg && k_reg <= last_h_reg)
        else $error("slot counter beyond configured range");

    // a finished sum with a free output register is shown next cycle
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !out_valid_reg |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not delivered");

endmodule
